// ----- rtl/x86_multiply_divide_unit_core_macros.svh -----
// Assertion macros shared by the multiply/divide unit
`ifndef X86_MULTIPLY_DIVIDE_UNIT_CORE_MACROS_SVH
`define X86_MULTIPLY_DIVIDE_UNIT_CORE_MACROS_SVH

// same-cycle implication under the block clock and reset
`define MDU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("multiply/divide unit assertion failed");

// next-cycle implication under the block clock and reset
`define MDU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("multiply/divide unit assertion failed");

`endif

// ----- rtl/mdu_pkg.sv -----
// Types and constants of the multiply/divide unit
package mdu_pkg;
	localparam int OP_WORD_BIT = 0;
	localparam int OP_SGN_BIT = 1;
	localparam int OP_DIV_BIT = 2;
	localparam int STEPS_PER_STAGE = 8;
	localparam int DIV_STAGES = 4;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] acc_low;
		logic [15:0] acc_high;
		logic [15:0] operand;
	} mdu_in_t;

	typedef struct packed {
		logic [15:0] new_acc_low;
		logic [15:0] new_acc_high;
		logic        carry_overflow;
		logic        divide_error;
	} mdu_out_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] ax;
		logic [15:0] dx;
		logic [31:0] prod;
		logic [15:0] rem;
		logic [31:0] qd;
		logic [15:0] dvs;
		logic        q_neg;
		logic        r_neg;
		logic        dvz;
	} mdu_pipe_t;
endpackage

// ----- rtl/x86_multiply_divide_unit_core.sv -----
// Top level of the pipelined 8086 multiply/divide unit
//
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_data  (op, acc_low, acc_high, operand)
// out     | out | out_valid/out_ready | out_data (new AX/DX, flags)
//
// Six register stages: prepare and multiply, four divide stages of eight
// restoring steps each (32 steps total), then sign fix and output register.
// One item per cycle while the pipe advances. The whole pipe advances together
// when the output register is empty or being taken. Reset clears valid bits only.
module x86_multiply_divide_unit_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mdu_pkg::mdu_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mdu_pkg::mdu_out_t out_data
);
	import mdu_pkg::*;

	`include "x86_multiply_divide_unit_core_macros.svh"

	logic      adv;
	logic      v_s [DIV_STAGES+1];
	mdu_pipe_t d_s [DIV_STAGES+1];

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	mdu_prep u_prep (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(in_valid), .in_data(in_data),
		.valid_s1(v_s[0]), .data_s1(d_s[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		mdu_div_stage u_div (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.valid_in(v_s[g]), .data_in(d_s[g]),
			.valid_q(v_s[g+1]), .data_q(d_s[g+1])
		);
	end

	mdu_finish u_finish (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.valid_in(v_s[DIV_STAGES]), .data_in(d_s[DIV_STAGES]),
		.out_valid(out_valid), .out_data(out_data)
	);

	`MDU_ASSERT_IMP(a_derr_no_cof, out_valid && out_data.divide_error, !out_data.carry_overflow)
	`MDU_ASSERT_NXT(a_s1_handoff, v_s[0] && adv, v_s[1])
	`MDU_ASSERT_NXT(a_last_hold, v_s[DIV_STAGES] && !adv, v_s[DIV_STAGES])
endmodule

// ----- rtl/mdu_prep.sv -----
// First stage: multiply, operand magnitudes and sign bookkeeping
module mdu_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  mdu_pkg::mdu_in_t   in_data,
	output logic               valid_s1,
	output mdu_pkg::mdu_pipe_t data_s1
);
	import mdu_pkg::*;

	logic               word, sgn;
	logic signed [16:0] a_ext, b_ext;
	logic signed [33:0] prod;
	logic [31:0]        dvd, dabs;
	logic [15:0]        dvs, vabs;
	logic               dneg, vneg;
	mdu_pipe_t          nxt;

	always_comb begin
		word = in_data.op[OP_WORD_BIT];
		sgn = in_data.op[OP_SGN_BIT];
		a_ext = word ? {sgn & in_data.acc_low[15], in_data.acc_low}
			: {{9{sgn & in_data.acc_low[7]}}, in_data.acc_low[7:0]};
		b_ext = word ? {sgn & in_data.operand[15], in_data.operand}
			: {{9{sgn & in_data.operand[7]}}, in_data.operand[7:0]};
		prod = a_ext * b_ext;
		dvd = word ? {in_data.acc_high, in_data.acc_low}
			: {{16{sgn & in_data.acc_low[15]}}, in_data.acc_low};
		dvs = word ? in_data.operand
			: {{8{sgn & in_data.operand[7]}}, in_data.operand[7:0]};
		dneg = sgn & dvd[31];
		vneg = sgn & dvs[15];
		dabs = dneg ? (32'd0 - dvd) : dvd;
		vabs = vneg ? (16'd0 - dvs) : dvs;
		nxt.op = in_data.op;
		nxt.ax = in_data.acc_low;
		nxt.dx = in_data.acc_high;
		nxt.prod = prod[31:0];
		nxt.rem = 16'd0;
		nxt.qd = dabs;
		nxt.dvs = vabs;
		nxt.q_neg = dneg ^ vneg;
		nxt.r_neg = dneg;
		nxt.dvz = word ? (in_data.operand == 16'd0) : (in_data.operand[7:0] == 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= nxt;
		end
	end
endmodule

// ----- rtl/mdu_div_stage.sv -----
// Divide stage: a slice of restoring division steps and its register
module mdu_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_in,
	input  mdu_pkg::mdu_pipe_t data_in,
	output logic               valid_q,
	output mdu_pkg::mdu_pipe_t data_q
);
	import mdu_pkg::*;

	mdu_pipe_t   nxt;
	logic [16:0] t;
	logic        ge;

	always_comb begin
		nxt = data_in;
		t = 17'd0;
		ge = 1'b0;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			t = {nxt.rem, nxt.qd[31]};
			ge = (t >= {1'b0, nxt.dvs});
			if (ge) begin
				t = t - {1'b0, nxt.dvs};
			end
			nxt.rem = t[15:0];
			nxt.qd = {nxt.qd[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nxt;
		end
	end
endmodule

// ----- rtl/mdu_finish.sv -----
// Last stage: sign fix, flags and result assembly into the output register
module mdu_finish (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_in,
	input  mdu_pkg::mdu_pipe_t data_in,
	output logic               out_valid,
	output mdu_pkg::mdu_out_t  out_data
);
	import mdu_pkg::*;

	logic [15:0] q16, r16;
	logic        word, sgn;
	mdu_out_t    nxt;

	always_comb begin
		word = data_in.op[OP_WORD_BIT];
		sgn = data_in.op[OP_SGN_BIT];
		q16 = data_in.q_neg ? (16'd0 - data_in.qd[15:0]) : data_in.qd[15:0];
		r16 = data_in.r_neg ? (16'd0 - data_in.rem) : data_in.rem;
		nxt.new_acc_low = data_in.ax;
		nxt.new_acc_high = data_in.dx;
		nxt.carry_overflow = 1'b0;
		nxt.divide_error = 1'b0;
		if (data_in.op[OP_DIV_BIT]) begin
			if (data_in.dvz) begin
				nxt.divide_error = 1'b1;
			end else if (word) begin
				nxt.new_acc_low = q16;
				nxt.new_acc_high = r16;
			end else begin
				nxt.new_acc_low = {r16[7:0], q16[7:0]};
			end
		end else if (word) begin
			nxt.new_acc_low = data_in.prod[15:0];
			nxt.new_acc_high = data_in.prod[31:16];
			nxt.carry_overflow = sgn ? (data_in.prod[31:16] != {16{data_in.prod[15]}})
				: (data_in.prod[31:16] != 16'd0);
		end else begin
			nxt.new_acc_low = data_in.prod[15:0];
			nxt.carry_overflow = sgn ? (data_in.prod[15:8] != {8{data_in.prod[7]}})
				: (data_in.prod[15:8] != 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= nxt;
		end
	end
endmodule

// ----- dv/tb.sv -----
// Testbench for the 8086 multiply/divide unit: directed and random items checked against a predictor
`timescale 1ns / 1ps
module tb;
	import mdu_pkg::*;

	typedef enum logic [2:0] {
		OP_MUL8   = 3'd0,
		OP_MUL16  = 3'd1,
		OP_IMUL8  = 3'd2,
		OP_IMUL16 = 3'd3,
		OP_DIV8   = 3'd4,
		OP_DIV16  = 3'd5,
		OP_IDIV8  = 3'd6,
		OP_IDIV16 = 3'd7
	} mdu_op_e;

	localparam int LATENCY = 6;
	localparam int CYCLE_LIMIT = 400000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	mdu_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	mdu_out_t out_data;

	mdu_out_t result_queue[$];
	int       error_count;
	int       items_sent;
	int       results_seen;
	int       cycle_count;
	int       op_seen[8];
	int       div_errors_seen;

	x86_multiply_divide_unit_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic mdu_out_t compute_mul_div(mdu_in_t item);
		mdu_out_t                r;
		logic [15:0]             ax;
		logic [15:0]             dx;
		logic [15:0]             src;
		logic [7:0]              src8;
		logic [31:0]             up;
		logic signed [31:0]      sp;
		logic [31:0]             dvd;
		logic signed [47:0]      sa;
		logic signed [47:0]      sb;
		logic signed [47:0]      sq;
		logic signed [47:0]      sr;
		ax = item.acc_low;
		dx = item.acc_high;
		src = item.operand;
		src8 = src[7:0];
		r.new_acc_low = ax;
		r.new_acc_high = dx;
		r.carry_overflow = 1'b0;
		r.divide_error = 1'b0;
		case (mdu_op_e'(item.op))
			OP_MUL8: begin
				r.new_acc_low = ax[7:0] * src8;
				r.carry_overflow = r.new_acc_low[15:8] != 8'h00;
			end
			OP_MUL16: begin
				up = ax * src;
				{r.new_acc_high, r.new_acc_low} = up;
				r.carry_overflow = up[31:16] != 16'h0000;
			end
			OP_IMUL8: begin
				sp = $signed(ax[7:0]) * $signed(src8);
				r.new_acc_low = sp[15:0];
				r.carry_overflow = sp[15:8] != {8{sp[7]}};
			end
			OP_IMUL16: begin
				sp = $signed(ax) * $signed(src);
				{r.new_acc_high, r.new_acc_low} = sp;
				r.carry_overflow = sp[31:16] != {16{sp[15]}};
			end
			OP_DIV8: begin
				if (src8 == 8'h00) begin
					r.divide_error = 1'b1;
				end else begin
					r.new_acc_low = {8'(ax % src8), 8'(ax / src8)};
				end
			end
			OP_DIV16: begin
				if (src == 16'h0000) begin
					r.divide_error = 1'b1;
				end else begin
					dvd = {dx, ax};
					r.new_acc_low = 16'(dvd / src);
					r.new_acc_high = 16'(dvd % src);
				end
			end
			OP_IDIV8: begin
				if (src8 == 8'h00) begin
					r.divide_error = 1'b1;
				end else begin
					sa = 48'($signed(ax));
					sb = 48'($signed(src8));
					sq = sa / sb;
					sr = sa % sb;
					r.new_acc_low = {sr[7:0], sq[7:0]};
				end
			end
			default: begin
				if (src == 16'h0000) begin
					r.divide_error = 1'b1;
				end else begin
					sa = 48'($signed({dx, ax}));
					sb = 48'($signed(src));
					sq = sa / sb;
					sr = sa % sb;
					r.new_acc_low = sq[15:0];
					r.new_acc_high = sr[15:0];
				end
			end
		endcase
		return r;
	endfunction

	function automatic int gap_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_item(input logic [2:0] op, input logic [15:0] ax,
			input logic [15:0] dx, input logic [15:0] src);
		mdu_in_t item;
		int      gap;
		item.op = op;
		item.acc_low = ax;
		item.acc_high = dx;
		item.operand = src;
		in_data <= item;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		result_queue.push_back(compute_mul_div(item));
		op_seen[op]++;
		items_sent++;
		@(negedge clk);
		gap = gap_length();
		if (gap != 0 && $urandom_range(0, 3) != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (result_queue.size() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic test_multiply_corners();
		send_item(OP_MUL8, 16'hABFF, 16'h1234, 16'h77FF);
		send_item(OP_MUL8, 16'h0000, 16'hFFFF, 16'h00FF);
		send_item(OP_MUL16, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_item(OP_MUL16, 16'h0003, 16'hFFFF, 16'h0005);
		send_item(OP_IMUL8, 16'h0080, 16'h0000, 16'h0080);
		send_item(OP_IMUL8, 16'h00FF, 16'h5555, 16'h0001);
		send_item(OP_IMUL8, 16'h0010, 16'h0000, 16'h0008);
		send_item(OP_IMUL16, 16'h8000, 16'h0000, 16'h8000);
		send_item(OP_IMUL16, 16'hFFFF, 16'h0000, 16'h0001);
		send_item(OP_IMUL16, 16'h7FFF, 16'hAAAA, 16'h7FFF);
	endtask

	task automatic test_divide_corners();
		send_item(OP_DIV8, 16'h1234, 16'h5678, 16'hFF00);
		send_item(OP_DIV16, 16'h1234, 16'h5678, 16'h0000);
		send_item(OP_IDIV8, 16'hFFFF, 16'h0000, 16'h1200);
		send_item(OP_IDIV16, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_item(OP_DIV8, 16'hFFFF, 16'h0000, 16'h0001);
		send_item(OP_DIV16, 16'hFFFF, 16'hFFFF, 16'h0001);
		send_item(OP_DIV16, 16'hFFFF, 16'hFFFE, 16'hFFFF);
		send_item(OP_IDIV8, 16'h8000, 16'h0000, 16'h00FF);
		send_item(OP_IDIV8, 16'hFF81, 16'h0000, 16'h0007);
		send_item(OP_IDIV16, 16'h0000, 16'h8000, 16'hFFFF);
		send_item(OP_IDIV16, 16'hFFF9, 16'hFFFF, 16'h0002);
		send_item(OP_IDIV16, 16'h0007, 16'h0000, 16'hFFFE);
		send_item(OP_IDIV8, 16'h0064, 16'hFFFF, 16'h00F9);
		drain();
	endtask

	task automatic test_random_items(input int count);
		logic [15:0] src;
		for (int i = 0; i < count; i++) begin
			src = 16'($urandom());
			case ($urandom_range(0, 5))
				0: src = 16'(src[0]);
				1: src[7:0] = 8'h00;
				2: src = 16'($urandom_range(1, 15));
				default: ;
			endcase
			send_item(3'($urandom_range(0, 7)), 16'($urandom()),
				16'($urandom()), src);
			if (i == count / 2) drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_multiply_corners();
		test_divide_corners();
		test_random_items(680);
		drain();
		$display("Covered %0d items over all eight operations, %0d divide errors,",
			items_sent, div_errors_seen);
		$display("with random stalls on both channels and a full drain mid-run.");
		if (error_count == 0 && results_seen == items_sent) begin
			$display("x86_multiply_divide_unit_core: match");
		end else begin
			$display("x86_multiply_divide_unit_core: mismatch");
		end
		$finish;
	end

	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
				hold = gap_length();
				if ($urandom_range(0, 2) != 0) hold = 0;
			end
		end
	end

	always @(posedge clk) begin
		mdu_out_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (result_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				error_count++;
			end else begin
				want = result_queue.pop_front();
				if (want.divide_error) div_errors_seen++;
				if (out_data.new_acc_low !== want.new_acc_low) begin
					$display("%0t: new_acc_low expected %h actual %h",
						$time, want.new_acc_low, out_data.new_acc_low);
					error_count++;
				end
				if (out_data.new_acc_high !== want.new_acc_high) begin
					$display("%0t: new_acc_high expected %h actual %h",
						$time, want.new_acc_high, out_data.new_acc_high);
					error_count++;
				end
				if (out_data.carry_overflow !== want.carry_overflow) begin
					$display("%0t: carry_overflow expected %b actual %b",
						$time, want.carry_overflow, out_data.carry_overflow);
					error_count++;
				end
				if (out_data.divide_error !== want.divide_error) begin
					$display("%0t: divide_error expected %b actual %b",
						$time, want.divide_error, out_data.divide_error);
					error_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles", cycle_count);
				$display("x86_multiply_divide_unit_core: mismatch");
				$finish;
			end
		end
	end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mdu_pkg.sv
rtl/mdu_prep.sv
rtl/mdu_div_stage.sv
rtl/mdu_finish.sv
rtl/x86_multiply_divide_unit_core.sv
dv/tb.sv
